FILE: hdl/npt_pkg.sv
// Shared types, constants and the microcode program of the nth-prime block.
package npt_pkg;

    localparam int PRIME_W    = 18;
    localparam int COUNT_W    = 16;
    localparam int NTH_W      = 13;
    localparam int SEED_COUNT = 6;
    localparam int UPC_W      = 5;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD_N   = 4'd1,
        OP_RD_LAST  = 4'd2,
        OP_SET_CAND = 4'd3,
        OP_RD_IDX   = 4'd4,
        OP_LOAD_P   = 4'd5,
        OP_SQ       = 4'd6,
        OP_DIV_INIT = 4'd7,
        OP_DIV_STEP = 4'd8,
        OP_NEXT_IDX = 4'd9,
        OP_NEXT_CAND = 4'd10,
        OP_APPEND   = 4'd11,
        OP_RD_N     = 4'd12,
        OP_EMIT     = 4'd13,
        OP_EMIT_ERR = 4'd14
    } t_op;

    typedef enum logic [3:0] {
        C_NONE     = 4'd0,
        C_ALWAYS   = 4'd1,
        C_N_ZERO   = 4'd2,
        C_N_BIG    = 4'd3,
        C_HAVE     = 4'd4,
        C_IDX_END  = 4'd5,
        C_SQ_BIG   = 4'd6,
        C_DIV_MORE = 4'd7,
        C_REM_ZERO = 4'd8
    } t_cond;

    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_IN   = 2'd1,
        W_OUT  = 2'd2
    } t_wt;

    typedef struct packed {
        t_wt              wt;
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic n_zero;
        logic n_big;
        logic have;
        logic idx_end;
        logic sq_big;
        logic div_more;
        logic rem_zero;
    } t_stat;

    localparam logic [UPC_W-1:0] S_IDLE      = 5'd0;
    localparam logic [UPC_W-1:0] S_CHK_ZERO  = 5'd1;
    localparam logic [UPC_W-1:0] S_CHK_BIG   = 5'd2;
    localparam logic [UPC_W-1:0] S_LOOP      = 5'd3;
    localparam logic [UPC_W-1:0] S_SET_CAND  = 5'd4;
    localparam logic [UPC_W-1:0] S_TRY       = 5'd5;
    localparam logic [UPC_W-1:0] S_LOAD_P    = 5'd6;
    localparam logic [UPC_W-1:0] S_SQ        = 5'd7;
    localparam logic [UPC_W-1:0] S_SQ_CHK    = 5'd8;
    localparam logic [UPC_W-1:0] S_DIV       = 5'd9;
    localparam logic [UPC_W-1:0] S_REM_CHK   = 5'd10;
    localparam logic [UPC_W-1:0] S_NEXT_IDX  = 5'd11;
    localparam logic [UPC_W-1:0] S_NEXT_CAND = 5'd12;
    localparam logic [UPC_W-1:0] S_APPEND    = 5'd13;
    localparam logic [UPC_W-1:0] S_RD_N      = 5'd14;
    localparam logic [UPC_W-1:0] S_EMIT      = 5'd15;
    localparam logic [UPC_W-1:0] S_EMIT_ERR  = 5'd16;

    function automatic t_uword ucode(input logic [UPC_W-1:0] upc);
        t_uword w;
        unique case (upc)
            S_IDLE:      w = '{W_IN,   OP_LOAD_N,    C_NONE,     S_IDLE};
            S_CHK_ZERO:  w = '{W_NONE, OP_NONE,      C_N_ZERO,   S_IDLE};
            S_CHK_BIG:   w = '{W_NONE, OP_NONE,      C_N_BIG,    S_EMIT_ERR};
            S_LOOP:      w = '{W_NONE, OP_RD_LAST,   C_HAVE,     S_RD_N};
            S_SET_CAND:  w = '{W_NONE, OP_SET_CAND,  C_NONE,     S_IDLE};
            S_TRY:       w = '{W_NONE, OP_RD_IDX,    C_IDX_END,  S_APPEND};
            S_LOAD_P:    w = '{W_NONE, OP_LOAD_P,    C_NONE,     S_IDLE};
            S_SQ:        w = '{W_NONE, OP_SQ,        C_NONE,     S_IDLE};
            S_SQ_CHK:    w = '{W_NONE, OP_DIV_INIT,  C_SQ_BIG,   S_APPEND};
            S_DIV:       w = '{W_NONE, OP_DIV_STEP,  C_DIV_MORE, S_DIV};
            S_REM_CHK:   w = '{W_NONE, OP_NONE,      C_REM_ZERO, S_NEXT_CAND};
            S_NEXT_IDX:  w = '{W_NONE, OP_NEXT_IDX,  C_ALWAYS,   S_TRY};
            S_NEXT_CAND: w = '{W_NONE, OP_NEXT_CAND, C_ALWAYS,   S_TRY};
            S_APPEND:    w = '{W_NONE, OP_APPEND,    C_ALWAYS,   S_LOOP};
            S_RD_N:      w = '{W_NONE, OP_RD_N,      C_NONE,     S_IDLE};
            S_EMIT:      w = '{W_OUT,  OP_EMIT,      C_ALWAYS,   S_IDLE};
            S_EMIT_ERR:  w = '{W_OUT,  OP_EMIT_ERR,  C_ALWAYS,   S_IDLE};
            default:     w = '{W_NONE, OP_NONE,      C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [PRIME_W-1:0] seed_prime(input logic [2:0] idx);
        logic [PRIME_W-1:0] p;
        unique case (idx)
            3'd0:    p = PRIME_W'(2);
            3'd1:    p = PRIME_W'(3);
            3'd2:    p = PRIME_W'(5);
            3'd3:    p = PRIME_W'(7);
            3'd4:    p = PRIME_W'(11);
            3'd5:    p = PRIME_W'(13);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/npt_req_if.sv
// Request channel: valid/ready handshake carrying the wanted prime count.
interface npt_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

FILE: hdl/npt_rsp_if.sv
// Result channel: valid/ready handshake carrying the prime and the error flag.
interface npt_rsp_if;
    logic        valid;
    logic        ready;
    logic [12:0] nth_prime;
    logic        count_too_large;

    modport source (output valid, output nth_prime, output count_too_large, input ready);
    modport sink   (input valid, input nth_prime, input count_too_large, output ready);
endinterface

FILE: hdl/npt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module npt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/npt_seq.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module npt_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  npt_pkg::t_stat i_stat,
    output npt_pkg::t_ctl  o_ctl
);
    import npt_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             blocked;
    logic             take;

    assign uw = ucode(r_upc);

    always_comb begin
        unique case (uw.wt)
            W_IN:    blocked = !i_stat.in_valid;
            W_OUT:   blocked = i_stat.out_busy;
            default: blocked = 1'b0;
        endcase
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:   take = 1'b1;
            C_N_ZERO:   take = i_stat.n_zero;
            C_N_BIG:    take = i_stat.n_big;
            C_HAVE:     take = i_stat.have;
            C_IDX_END:  take = i_stat.idx_end;
            C_SQ_BIG:   take = i_stat.sq_big;
            C_DIV_MORE: take = i_stat.div_more;
            C_REM_ZERO: take = i_stat.rem_zero;
            default:    take = 1'b0;
        endcase
    end

    always_comb begin
        if (blocked) begin
            n_upc = r_upc;
        end else if (take) begin
            n_upc = uw.target;
        end else begin
            n_upc = r_upc + UPC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl.op   = uw.op;
    assign o_ctl.fire = !blocked;

endmodule

FILE: hdl/npt_datapath.sv
// Datapath: request and result registers, prime table, square and serial remainder unit.
module npt_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  npt_pkg::t_ctl  i_ctl,
    output npt_pkg::t_stat o_stat,
    npt_req_if.sink        i_req,
    npt_rsp_if.source      o_rsp
);
    import npt_pkg::*;

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int DCW = $clog2(PRIME_W);

    logic [COUNT_W-1:0]   r_n;
    logic [CW-1:0]        r_known;
    logic [PRIME_W-1:0]   r_cand;
    logic [CW-1:0]        r_idx;
    logic [PRIME_W-1:0]   r_p;
    logic [2*PRIME_W-1:0] r_sq;
    logic [PRIME_W-1:0]   r_rem;
    logic [PRIME_W-1:0]   r_sh;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_seed_hit;
    logic [PRIME_W-1:0]   r_seed_val;
    logic                 r_out_valid;
    logic [NTH_W-1:0]     r_out_prime;
    logic                 r_out_err;

    logic                 act;
    logic                 re;
    logic                 we;
    logic [AW-1:0]        raddr;
    logic [CW-1:0]        known_m1;
    logic [COUNT_W-1:0]   n_m1;
    logic [COUNT_W-1:0]   known_ext;
    logic [PRIME_W-1:0]   ram_q;
    logic [PRIME_W-1:0]   rd;
    logic [PRIME_W:0]     div_t;
    logic [PRIME_W:0]     div_p;
    logic [PRIME_W-1:0]   n_rem;
    logic [2*PRIME_W-1:0] sq_full;

    assign act       = i_ctl.fire;
    assign known_m1  = r_known - CW'(1);
    assign n_m1      = r_n - COUNT_W'(1);
    assign known_ext = COUNT_W'(r_known);
    assign we        = act && (i_ctl.op == OP_APPEND);

    always_comb begin
        re    = 1'b0;
        raddr = '0;
        case (i_ctl.op)
            OP_RD_LAST: begin
                re    = act;
                raddr = known_m1[AW-1:0];
            end
            OP_RD_IDX: begin
                re    = act;
                raddr = r_idx[AW-1:0];
            end
            OP_RD_N: begin
                re    = act;
                raddr = n_m1[AW-1:0];
            end
            default: begin
                re    = 1'b0;
                raddr = '0;
            end
        endcase
    end

    npt_ram #(
        .WIDTH (PRIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_known[AW-1:0]),
        .i_wdata (r_cand),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign rd = r_seed_hit ? r_seed_val : ram_q;

    assign div_t   = {r_rem, r_sh[PRIME_W-1]};
    assign div_p   = {1'b0, r_p};
    assign n_rem   = (div_t >= div_p) ? PRIME_W'(div_t - div_p) : div_t[PRIME_W-1:0];
    assign sq_full = {{PRIME_W{1'b0}}, r_p} * {{PRIME_W{1'b0}}, r_p};

    always_ff @(posedge i_clk) begin
        if (re) begin
            r_seed_hit <= (raddr < AW'(SEED_COUNT));
            r_seed_val <= seed_prime(raddr[2:0]);
        end
        if (act) begin
            case (i_ctl.op)
                OP_LOAD_N:    r_n <= i_req.prime_count;
                OP_SET_CAND: begin
                    r_cand <= rd + PRIME_W'(2);
                    r_idx  <= CW'(1);
                end
                OP_LOAD_P:    r_p  <= rd;
                OP_SQ:        r_sq <= sq_full;
                OP_DIV_INIT: begin
                    r_rem  <= '0;
                    r_sh   <= r_cand;
                    r_dcnt <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem  <= n_rem;
                    r_sh   <= {r_sh[PRIME_W-2:0], 1'b0};
                    r_dcnt <= r_dcnt + DCW'(1);
                end
                OP_NEXT_IDX:  r_idx <= r_idx + CW'(1);
                OP_NEXT_CAND: begin
                    r_cand <= r_cand + PRIME_W'(2);
                    r_idx  <= CW'(1);
                end
                OP_EMIT: begin
                    r_out_prime <= rd[NTH_W-1:0];
                    r_out_err   <= 1'b0;
                end
                OP_EMIT_ERR: begin
                    r_out_prime <= '0;
                    r_out_err   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known     <= CW'(SEED_COUNT);
            r_out_valid <= 1'b0;
        end else begin
            if (we) begin
                r_known <= r_known + CW'(1);
            end
            if (act && (i_ctl.op == OP_EMIT || i_ctl.op == OP_EMIT_ERR)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready           = (i_ctl.op == OP_LOAD_N);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.nth_prime       = r_out_prime;
    assign o_rsp.count_too_large = r_out_err;

    assign o_stat.in_valid = i_req.valid;
    assign o_stat.out_busy = r_out_valid && !o_rsp.ready;
    assign o_stat.n_zero   = (r_n == '0);
    assign o_stat.n_big    = ({1'b0, r_n} > (COUNT_W + 1)'(TABLE_DEPTH));
    assign o_stat.have     = (known_ext >= r_n);
    assign o_stat.idx_end  = (r_idx >= r_known);
    assign o_stat.sq_big   = (r_sq > {{PRIME_W{1'b0}}, r_cand});
    assign o_stat.div_more = (r_dcnt != DCW'(PRIME_W - 1));
    assign o_stat.rem_zero = (r_rem == '0);

    a_known_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_known <= CW'(TABLE_DEPTH))
        else $error("prime count beyond table depth");

    a_append_needed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (known_ext < r_n))
        else $error("table extended past the requested count");

    a_err_only_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act && i_ctl.op == OP_EMIT_ERR) |-> ({1'b0, r_n} > (COUNT_W + 1)'(TABLE_DEPTH)))
        else $error("error result for a count within the table");

    a_emit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act && i_ctl.op == OP_EMIT) |-> (known_ext >= r_n && r_n != '0))
        else $error("result read from an unfilled table entry");

endmodule

FILE: hdl/nth_prime_trial_division.sv
// Top level of the nth-prime block: microcode sequencer driving the prime datapath.
//
//   channel  modport  payload                          transfer when
//   i_req    sink     prime_count[15:0]                valid && ready
//   o_rsp    source   nth_prime[12:0], count_too_large valid && ready
//
// A zero count ends with no result, a count beyond the depth with the error result.
// Each trial divisor runs the one-bit-a-cycle remainder loop;
// each appended prime adds candidate setup, the closing square check, write, reread.
// Reset sets the known count to the six seed primes, served from a constant table.
// A waiting result does not stop the next request from being taken; the result step
// holds until the previous result transfers.
module nth_prime_trial_division #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    npt_req_if.sink   i_req,
    npt_rsp_if.source o_rsp
);
    import npt_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    npt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    npt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
